/* rtl/bpld_pkg.sv */
// ----------------------------------------------------------------------------
// bpld_pkg
// Types, constants and register codes shared by the button press detector.
// ----------------------------------------------------------------------------
package bpld_pkg;

    localparam int BUTTONS_DEF = 4;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;
    localparam int QDepth      = 4;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        REG_ACTIVE   = 3'd0,
        REG_DEBOUNCE = 3'd1,
        REG_LP_EN    = 3'd2,
        REG_THR0     = 3'd3,
        REG_THR1     = 3'd4,
        REG_THR2     = 3'd5,
        REG_THR3     = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        EV_SHORT      = 2'd0,
        EV_LONG_START = 2'd1,
        EV_LONG_END   = 2'd2
    } t_event_kind;

    typedef struct packed {
        logic        action;
        logic [1:0]  button_index;
        logic        level;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        t_event_kind event_kind;
        logic [1:0]  event_button;
        logic [15:0] press_count;
        logic [15:0] total_presses;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [2:0]       active_buttons;
        logic [15:0]      debounce_ms;
        logic [3:0]       long_press_enable;
        logic [3:0][15:0] hold_threshold;
    } t_cfg;

    // per-button entry of the state memory
    typedef struct packed {
        logic        prev_level;
        logic [31:0] press_stamp;
        logic        held;
        logic [31:0] hold_start;
        logic        long_fired;
    } t_btn_state;

    localparam t_btn_state BTN_RESET = '{
        prev_level:  1'b1,
        press_stamp: 32'd0,
        held:        1'b0,
        hold_start:  32'd0,
        long_fired:  1'b0
    };

endpackage

/* rtl/bpld_if.sv */
// ----------------------------------------------------------------------------
// bpld_in_if / bpld_out_if
// Valid/ready channels for button samples and detector events.
// ----------------------------------------------------------------------------
interface bpld_in_if import bpld_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bpld_out_if import bpld_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/button_press_long_press_detector_core.sv */
// ----------------------------------------------------------------------------
// button_press_long_press_detector_core
// Debounced press counting and long-press detection for active-low buttons.
// ----------------------------------------------------------------------------
// Each accepted sample reads its button's entry from a registered-read state
// memory, is evaluated and written back in the next cycle, and its zero, one or
// two events enter a four-entry result queue. A new sample can be taken every
// cycle while the queue has room for two more events; while the output takes
// events, samples with no or one event run at one per cycle, and samples with
// two events are held back by the single event transfer per cycle on the output.
// Back-to-back samples of the same button are forwarded around the memory.
// State entries carry valid bits cleared by reset, so no clearing pass is needed.
// Press counts sit in flops; a clear command zeroes them all and produces no
// event. Input is held off in the cycle in which a register write completes.
// ----------------------------------------------------------------------------
module button_press_long_press_detector_core import bpld_pkg::*; #(
    parameter int BUTTONS = BUTTONS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bpld_in_if.sink            i_item,
    bpld_out_if.source         o_event,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int         AW     = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int         QAW    = $clog2(QDepth);
    localparam int         QCW    = $clog2(QDepth + 1);
    localparam logic [3:0] BtnLim = 4'(BUTTONS);

    t_cfg cfg;

    bpld_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // ---------------- state memory and stage 1 ----------------
    t_btn_state r_mem [BUTTONS];
    t_btn_state r_rdata;
    t_btn_state r_fwd_data;
    logic       r_fwd;
    logic       r_vld [BUTTONS];

    logic       r_s1_vld;
    t_in_item   r_s1;

    logic [15:0] r_count [BUTTONS];
    logic [15:0] r_sum;
    logic        r_clr_prev;
    logic        r_inc_prev;

    logic        in_fire;
    logic        cfg_wr;
    logic [AW-1:0] in_addr;
    logic [AW-1:0] s1_addr;
    logic        b_ok;
    logic        s1_wr;
    logic        s1_clr;
    logic        en;
    logic [15:0] thr;
    t_btn_state  cur;
    t_btn_state  n_state;
    logic [31:0] since_press;
    logic [31:0] since_hold;
    logic        fall;
    logic        rise;
    logic        acc;
    logic        reach;
    logic        ls;
    logic        ev_b;
    t_event_kind kind_b;
    logic        inc;
    logic [15:0] sum_act;
    logic [15:0] base_total;
    logic [15:0] tot_out;
    logic [15:0] cnt_out;
    logic [1:0]  s1_push;
    t_out_item   ev0;
    t_out_item   ev1;

    // ---------------- result queue ----------------
    t_out_item      r_q [QDepth];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;
    logic           pop;
    logic [3:0]     q_room;

    assign cfg_wr  = psel & penable & pwrite;
    assign q_room  = 4'(QDepth) - 4'(r_cnt);
    assign i_item.ready = !cfg_wr && (4'(s1_push) + 4'd2 <= q_room);
    assign in_fire = i_item.valid & i_item.ready;
    assign in_addr = AW'(i_item.data.button_index);
    assign s1_addr = AW'(r_s1.button_index);

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rdata <= r_mem[in_addr];
        end
        if (s1_wr) begin
            r_mem[s1_addr] <= n_state;
        end
        r_fwd_data <= n_state;
        r_s1       <= i_item.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_fwd      <= 1'b0;
            r_clr_prev <= 1'b0;
            r_inc_prev <= 1'b0;
            r_sum      <= '0;
            for (int i = 0; i < BUTTONS; i++) begin
                r_vld[i]   <= 1'b0;
                r_count[i] <= '0;
            end
        end else begin
            r_s1_vld   <= in_fire;
            r_fwd      <= in_fire & s1_wr & (in_addr == s1_addr);
            r_clr_prev <= s1_clr;
            r_inc_prev <= inc;
            r_sum      <= sum_act;
            if (s1_wr) begin
                r_vld[s1_addr] <= 1'b1;
            end
            if (s1_clr) begin
                for (int i = 0; i < BUTTONS; i++) begin
                    r_count[i] <= '0;
                end
            end else if (inc) begin
                r_count[s1_addr] <= r_count[s1_addr] + 16'd1;
            end
        end
    end

    // running total is a registered sum of the counts and misses the last increment; correct for it
    always_comb begin
        sum_act = '0;
        for (int i = 0; i < BUTTONS; i++) begin
            if (4'(i) < {1'b0, cfg.active_buttons}) begin
                sum_act = sum_act + r_count[i];
            end
        end
    end

    assign base_total = r_clr_prev ? 16'd0 : r_sum + {15'd0, r_inc_prev};

    assign b_ok   = ({2'b00, r_s1.button_index} < BtnLim) &&
                    ({1'b0, r_s1.button_index} < cfg.active_buttons);
    assign s1_wr  = r_s1_vld && (r_s1.action == ACT_SAMPLE) && b_ok;
    assign s1_clr = r_s1_vld && (r_s1.action == ACT_CLEAR);
    assign en     = cfg.long_press_enable[r_s1.button_index];
    assign thr    = cfg.hold_threshold[r_s1.button_index];

    always_comb begin
        if (r_fwd) begin
            cur = r_fwd_data;
        end else if (r_vld[s1_addr]) begin
            cur = r_rdata;
        end else begin
            cur = BTN_RESET;
        end

        since_press = r_s1.now_ms - cur.press_stamp;
        since_hold  = r_s1.now_ms - cur.hold_start;
        fall = !r_s1.level && cur.prev_level;
        rise = r_s1.level && !cur.prev_level;
        acc  = fall && (since_press > {16'd0, r_s1.now_ms[15:0] & 16'd0 | cfg.debounce_ms});

        n_state = cur;
        if (acc) begin
            n_state.press_stamp = r_s1.now_ms;
            n_state.held        = 1'b1;
            n_state.hold_start  = r_s1.now_ms;
            n_state.long_fired  = 1'b0;
        end

        // a fresh press has zero elapsed hold time
        reach = acc ? (thr == 16'd0) : (since_hold >= {16'd0, thr});
        ls    = s1_wr && n_state.held && !n_state.long_fired && en && reach;
        if (ls) begin
            n_state.long_fired = 1'b1;
        end

        ev_b   = 1'b0;
        inc    = 1'b0;
        kind_b = EV_SHORT;
        if (rise && n_state.held) begin
            if (n_state.long_fired) begin
                if (en) begin
                    ev_b   = s1_wr;
                    kind_b = EV_LONG_END;
                end
            end else begin
                ev_b = s1_wr;
                inc  = s1_wr;
            end
            n_state.held = 1'b0;
        end
        n_state.prev_level = r_s1.level;
    end

    assign cnt_out = r_count[s1_addr] + {15'd0, inc};
    assign tot_out = base_total + {15'd0, inc};
    assign s1_push = {1'b0, ls} + {1'b0, ev_b};

    always_comb begin
        ev0.event_kind    = ls ? EV_LONG_START : kind_b;
        ev0.event_button  = r_s1.button_index;
        ev0.press_count   = cnt_out;
        ev0.total_presses = tot_out;
        ev0.last          = !(ls && ev_b);
        ev1.event_kind    = kind_b;
        ev1.event_button  = r_s1.button_index;
        ev1.press_count   = cnt_out;
        ev1.total_presses = tot_out;
        ev1.last          = 1'b1;
    end

    assign pop           = o_event.valid & o_event.ready;
    assign o_event.valid = (r_cnt != '0);
    assign o_event.data  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (s1_push != 2'd0) begin
            r_q[r_wp] <= ev0;
        end
        if (s1_push == 2'd2) begin
            r_q[r_wp + QAW'(1)] <= ev1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + QAW'(s1_push);
            r_rp  <= r_rp + QAW'(pop);
            r_cnt <= r_cnt + QCW'(s1_push) - QCW'(pop);
        end
    end

    // ---------------- assertions ----------------
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (4'(s1_push) <= q_room))
        else $error("result queue overflow");

    a_pair_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !o_event.data.last) |=> o_event.valid)
        else $error("second event of a sample not ready after the first");

    a_clear_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_clr |=> (base_total == 16'd0))
        else $error("total not zero after clear");

    a_fwd_same_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> (r_s1_vld && $past(s1_wr) && r_vld[s1_addr]))
        else $error("forwarded state without a preceding write");

endmodule

/* rtl/bpld_cfg.sv */
// ----------------------------------------------------------------------------
// bpld_cfg
// APB register file: active count, debounce time, long-press enables and
// per-button hold thresholds.
// ----------------------------------------------------------------------------
module bpld_cfg import bpld_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_buttons    <= 3'd4;
            r_cfg.debounce_ms       <= 16'd50;
            r_cfg.long_press_enable <= 4'd0;
            r_cfg.hold_threshold    <= {4{16'd1000}};
        end else if (wr_en) begin
            case (reg_sel)
                REG_ACTIVE:   r_cfg.active_buttons       <= pwdata[2:0];
                REG_DEBOUNCE: r_cfg.debounce_ms          <= pwdata[15:0];
                REG_LP_EN:    r_cfg.long_press_enable    <= pwdata[3:0];
                REG_THR0:     r_cfg.hold_threshold[0]    <= pwdata[15:0];
                REG_THR1:     r_cfg.hold_threshold[1]    <= pwdata[15:0];
                REG_THR2:     r_cfg.hold_threshold[2]    <= pwdata[15:0];
                REG_THR3:     r_cfg.hold_threshold[3]    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_sel)
            REG_ACTIVE:   prdata = {29'd0, r_cfg.active_buttons};
            REG_DEBOUNCE: prdata = {16'd0, r_cfg.debounce_ms};
            REG_LP_EN:    prdata = {28'd0, r_cfg.long_press_enable};
            REG_THR0:     prdata = {16'd0, r_cfg.hold_threshold[0]};
            REG_THR1:     prdata = {16'd0, r_cfg.hold_threshold[1]};
            REG_THR2:     prdata = {16'd0, r_cfg.hold_threshold[2]};
            REG_THR3:     prdata = {16'd0, r_cfg.hold_threshold[3]};
            default:      prdata = '0;
        endcase
    end

endmodule
